// ===== src/pulse_width_bit_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Pulse width bit decoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk with reset held off.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_BIT_DECODER_MACROS_SVH
`define PULSE_WIDTH_BIT_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pwbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse width bit decoder package
// Word types, register indexes, result codes and the controller interface.
// ----------------------------------------------------------------------------
package pwbd_pkg;

    typedef struct packed {
        logic [15:0] high_ticks;
        logic [15:0] low_ticks;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  symbol;
        logic [15:0] cycle_value;
        logic [15:0] threshold_value;
        logic        last;
    } t_out_word;

    localparam logic [2:0] CFG_SYNC_MIN   = 3'd0;
    localparam logic [2:0] CFG_SYNC_MAX   = 3'd1;
    localparam logic [2:0] CFG_SHORT_MIN  = 3'd2;
    localparam logic [2:0] CFG_SPLIT      = 3'd3;
    localparam logic [2:0] CFG_LONG_MAX   = 3'd4;

    localparam logic [15:0] RST_SYNC_MIN  = 16'd2500;
    localparam logic [15:0] RST_SYNC_MAX  = 16'd5000;
    localparam logic [15:0] RST_SHORT_MIN = 16'd250;
    localparam logic [15:0] RST_SPLIT     = 16'd1000;
    localparam logic [15:0] RST_LONG_MAX  = 16'd2000;

    localparam logic [1:0] KIND_SYMBOL = 2'd0;
    localparam logic [1:0] KIND_CAL    = 2'd1;
    localparam logic [1:0] KIND_FAIL   = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [2:0] SYM_BIT0 = 3'd0;
    localparam logic [2:0] SYM_BIT1 = 3'd1;
    localparam logic [2:0] SYM_FIX0 = 3'd2;
    localparam logic [2:0] SYM_FIX1 = 3'd3;
    localparam logic [2:0] SYM_RUN1 = 3'd5;
    localparam logic [2:0] SYM_RUN0 = 3'd6;

    localparam logic [3:0] PHASE_HUNT   = 4'd0;
    localparam logic [3:0] PHASE_LAST   = 4'd8;
    localparam logic [3:0] PHASE_DECODE = 4'd9;

    localparam int unsigned MAX_RESULTS = 8;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_ACCEPT = 4'd1;
    localparam logic [3:0] OP_HUNT   = 4'd2;
    localparam logic [3:0] OP_CAL    = 4'd3;
    localparam logic [3:0] OP_D1     = 4'd4;
    localparam logic [3:0] OP_D2     = 4'd5;
    localparam logic [3:0] OP_D3     = 4'd6;
    localparam logic [3:0] OP_TERM   = 4'd7;
    localparam logic [3:0] OP_LOOP   = 4'd8;
    localparam logic [3:0] OP_FIN    = 4'd9;
    localparam logic [3:0] OP_FIN2   = 4'd10;

    typedef struct packed {
        logic [3:0] op;
        logic       drain;
    } t_cmd;

    typedef struct packed {
        logic decoding;
        logic full;
        logic cnt_zero;
        logic hunt_cal;
        logic hunt_again;
        logic len_fits;
        logic term;
        logic dev_small;
        logic again;
        logic loop_go;
        logic drain_done;
    } t_status;

endpackage

// ===== src/pwbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Pulse width bit decoder controller
// Sequences hunt, calibration, decode steps and result draining per word.
// ----------------------------------------------------------------------------
module pwbd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pwbd_pkg::t_status i_status,
    output pwbd_pkg::t_cmd   o_cmd
);
    import pwbd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_STEP  = 4'd1;
    localparam logic [3:0] S_HUNT  = 4'd2;
    localparam logic [3:0] S_CAL   = 4'd3;
    localparam logic [3:0] S_D1    = 4'd4;
    localparam logic [3:0] S_D2    = 4'd5;
    localparam logic [3:0] S_D3    = 4'd6;
    localparam logic [3:0] S_TERM  = 4'd7;
    localparam logic [3:0] S_LOOP  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_FIN2  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;
    localparam logic [3:0] S_DRAIN = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NONE;
        o_cmd.drain = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_state  = S_STEP;
                end
            end
            S_STEP: begin
                if (i_status.full) begin
                    n_state = S_DONE;
                end else if (i_status.decoding) begin
                    n_state = S_D1;
                end else begin
                    n_state = S_HUNT;
                end
            end
            S_HUNT: begin
                o_cmd.op = OP_HUNT;
                if (i_status.hunt_cal) begin
                    n_state = S_CAL;
                end else if (i_status.hunt_again) begin
                    n_state = S_STEP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CAL: begin
                o_cmd.op = OP_CAL;
                n_state  = S_DONE;
            end
            S_D1: begin
                o_cmd.op = OP_D1;
                n_state  = S_D2;
            end
            S_D2: begin
                o_cmd.op = OP_D2;
                n_state  = i_status.len_fits ? S_DONE : S_D3;
            end
            S_D3: begin
                o_cmd.op = OP_D3;
                if (i_status.term) begin
                    n_state = S_TERM;
                end else if (i_status.dev_small) begin
                    n_state = i_status.again ? S_STEP : S_DONE;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_TERM: begin
                o_cmd.op = OP_TERM;
                n_state  = S_STEP;
            end
            S_LOOP: begin
                o_cmd.op = OP_LOOP;
                if (!i_status.loop_go) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.op = OP_FIN2;
                n_state  = i_status.again ? S_STEP : S_DONE;
            end
            S_DONE: begin
                n_state = i_status.cnt_zero ? S_IDLE : S_DRAIN;
            end
            S_DRAIN: begin
                o_cmd.drain = 1'b1;
                if (i_status.drain_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

`include "pulse_width_bit_decoder_macros.svh"

    `PWBD_ASSERT_NEXT(a_accept_step, r_state == S_IDLE && i_in_valid, r_state == S_STEP, "Accepted word did not start processing.")
    `PWBD_ASSERT_NEXT(a_full_done, r_state == S_STEP && i_status.full, r_state == S_DONE, "Processing continued past the result limit.")
    `PWBD_ASSERT_NOW(a_hunt_excl, r_state == S_HUNT, !(i_status.hunt_cal && i_status.hunt_again), "Hunt reported calibration and mismatch together.")

endmodule

// ===== src/pwbd_datapath.sv =====
// ----------------------------------------------------------------------------
// Pulse width bit decoder datapath
// Holds configuration, calibration and run state, the result buffer and output.
// ----------------------------------------------------------------------------
module pwbd_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_wr_data,
    input  pwbd_pkg::t_in_word  i_in_word,
    input  pwbd_pkg::t_cmd      i_cmd,
    output pwbd_pkg::t_status   o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pwbd_pkg::t_out_word o_out_word
);
    import pwbd_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  symbol;
        logic [15:0] cycle_value;
        logic [15:0] threshold_value;
    } t_entry;

    logic [15:0] r_sync_min, r_sync_max, r_short_min, r_split, r_long_max;
    logic [15:0] r_up, r_dn;
    logic [16:0] r_sum;
    logic [3:0]  r_phase;
    logic [15:0] r_short_sum, r_long_sum, r_cycle_sum;
    logic [15:0] r_win_high, r_win_low, r_avg, r_thr;
    logic signed [16:0] r_run_len;
    logic [15:0] r_run_high;
    logic        r_back;
    logic signed [18:0] r_len, r_dm, r_dev;
    logic [15:0] r_nh;
    logic [16:0] r_lim;
    logic        r_term, r_again;
    t_entry      r_buf [MAX_RESULTS];
    logic [3:0]  r_cnt, r_rd;
    t_out_word   r_out;
    logic        r_out_valid;

    logic        sync_hit, win, short_ok, long_ok, full, bit_hi;
    logic [16:0] short_add, long_add, cyc_add, run_add;
    logic [15:0] short_nx, long_nx, cyc_nx;
    logic [14:0] thr_sum;
    logic [15:0] thr_nx, avg_nx;
    logic        term_d1;
    logic [16:0] s_d1;
    logic signed [18:0] avg_s, eighth_s, prv_s, dplus, len_nx, fin_dev, neg_dev;
    logic        back_go, len_fits, dev_small, loop_go, fin_small;
    logic        e_valid, load_out;
    t_entry      e_word;

    always_comb begin
        full      = (r_cnt == 4'(MAX_RESULTS));
        bit_hi    = (r_run_high > r_thr);
        sync_hit  = (r_sync_min <= r_up) && (r_up <= r_sync_max) &&
                    (r_sync_min <= r_dn) && (r_dn <= r_sync_max);
        win       = ({1'b0, r_win_low} <= r_sum) && (r_sum <= {1'b0, r_win_high});
        short_ok  = (r_phase inside {4'd1, 4'd2, 4'd5, 4'd7}) && win &&
                    (r_short_min <= r_up) && (r_up <= r_split);
        long_ok   = (r_phase inside {4'd3, 4'd4, 4'd6, 4'd8}) && win &&
                    (r_split <= r_up) && (r_up <= r_long_max);
        short_add = {1'b0, r_short_sum} + {1'b0, r_up};
        long_add  = {1'b0, r_long_sum} + {1'b0, r_up};
        cyc_add   = {1'b0, r_cycle_sum} + r_sum;
        run_add   = {1'b0, r_run_high} + {1'b0, r_up};
        short_nx  = short_add[16] ? 16'hFFFF : short_add[15:0];
        long_nx   = long_add[16] ? 16'hFFFF : long_add[15:0];
        cyc_nx    = cyc_add[16] ? 16'hFFFF : cyc_add[15:0];
        thr_sum   = {1'b0, r_short_sum[15:2]} + {1'b0, r_long_sum[15:2]};
        thr_nx    = {2'b00, thr_sum[14:1]};
        avg_nx    = {3'b000, r_cycle_sum[15:3]};

        avg_s     = signed'({3'b000, r_avg});
        eighth_s  = signed'({6'b0, r_avg[15:3]});
        prv_s     = {{2{r_run_len[16]}}, r_run_len};
        term_d1   = ({1'b0, r_sum} > {r_avg, 2'b00});
        s_d1      = term_d1 ? ({1'b0, r_avg} + {4'b0, r_avg[15:3]}) : r_sum;

        len_fits  = (r_len <= avg_s);
        dplus     = r_len - avg_s;
        back_go   = r_back && (r_dm < dplus);
        dev_small = (r_dev < eighth_s);
        loop_go   = (r_len > signed'({2'b00, r_lim})) && !full;
        len_nx    = r_len - avg_s;
        fin_dev   = (r_len > avg_s) ? (r_len - avg_s) : (avg_s - r_len);
        neg_dev   = -r_dev;
        fin_small = dev_small;

        e_valid = 1'b0;
        e_word  = '0;
        case (i_cmd.op)
            OP_HUNT: begin
                if (!sync_hit && !short_ok && !long_ok && r_phase != PHASE_HUNT) begin
                    e_valid       = 1'b1;
                    e_word.kind   = KIND_FAIL;
                    e_word.symbol = 3'(r_phase - 4'd1);
                end
            end
            OP_CAL: begin
                e_valid                = 1'b1;
                e_word.kind            = KIND_CAL;
                e_word.cycle_value     = avg_nx;
                e_word.threshold_value = thr_nx;
            end
            OP_D3: begin
                if (r_term || dev_small) begin
                    e_valid       = 1'b1;
                    e_word.kind   = KIND_SYMBOL;
                    e_word.symbol = bit_hi ? SYM_BIT1 : SYM_BIT0;
                end
            end
            OP_TERM: begin
                e_valid     = 1'b1;
                e_word.kind = KIND_END;
            end
            OP_LOOP: begin
                if (loop_go) begin
                    e_valid       = 1'b1;
                    e_word.kind   = KIND_SYMBOL;
                    e_word.symbol = bit_hi ? SYM_RUN1 : SYM_RUN0;
                end
            end
            OP_FIN2: begin
                e_valid     = 1'b1;
                e_word.kind = KIND_SYMBOL;
                if (fin_small) begin
                    e_word.symbol = bit_hi ? SYM_BIT1 : SYM_BIT0;
                end else begin
                    e_word.symbol = bit_hi ? SYM_FIX1 : SYM_FIX0;
                end
            end
            default: begin
                e_valid = 1'b0;
            end
        endcase

        load_out = i_cmd.drain && (r_rd != r_cnt) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_min  <= RST_SYNC_MIN;
            r_sync_max  <= RST_SYNC_MAX;
            r_short_min <= RST_SHORT_MIN;
            r_split     <= RST_SPLIT;
            r_long_max  <= RST_LONG_MAX;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SYNC_MIN:  r_sync_min  <= i_cfg_wr_data;
                CFG_SYNC_MAX:  r_sync_max  <= i_cfg_wr_data;
                CFG_SHORT_MIN: r_short_min <= i_cfg_wr_data;
                CFG_SPLIT:     r_split     <= i_cfg_wr_data;
                CFG_LONG_MAX:  r_long_max  <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_valid && !full) begin
            r_buf[r_cnt[2:0]] <= e_word;
        end
        if (i_cmd.op == OP_ACCEPT) begin
            r_up  <= i_in_word.high_ticks;
            r_dn  <= i_in_word.low_ticks;
            r_sum <= {1'b0, i_in_word.high_ticks} + {1'b0, i_in_word.low_ticks};
        end
        if (i_cmd.op == OP_D1) begin
            r_len  <= prv_s + signed'({2'b00, s_d1});
            r_dm   <= avg_s - prv_s;
            r_nh   <= run_add[16] ? 16'hFFFF : run_add[15:0];
            r_lim  <= {r_avg, 1'b0} - {2'b00, r_avg[15:1]};
            r_term <= term_d1;
        end
        if (i_cmd.op == OP_D2 && !len_fits) begin
            r_dev   <= back_go ? r_dm : dplus;
            r_again <= back_go;
            r_term  <= r_term && !back_go;
            if (back_go) begin
                r_len <= prv_s;
            end
        end
        if (i_cmd.op == OP_LOOP && loop_go) begin
            r_len <= len_nx;
        end
        if (i_cmd.op == OP_FIN) begin
            r_dev <= fin_dev;
        end
        if (load_out) begin
            r_out.kind            <= r_buf[r_rd[2:0]].kind;
            r_out.symbol          <= r_buf[r_rd[2:0]].symbol;
            r_out.cycle_value     <= r_buf[r_rd[2:0]].cycle_value;
            r_out.threshold_value <= r_buf[r_rd[2:0]].threshold_value;
            r_out.last            <= (r_rd == r_cnt - 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PHASE_HUNT;
            r_short_sum <= '0;
            r_long_sum  <= '0;
            r_cycle_sum <= '0;
            r_win_high  <= '0;
            r_win_low   <= '0;
            r_avg       <= '0;
            r_thr       <= '0;
            r_run_len   <= '0;
            r_run_high  <= '0;
            r_back      <= 1'b0;
            r_cnt       <= '0;
            r_rd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (e_valid && !full) begin
                r_cnt <= r_cnt + 4'd1;
            end
            if (load_out) begin
                r_rd        <= r_rd + 4'd1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_ACCEPT: begin
                    r_cnt <= '0;
                    r_rd  <= '0;
                end
                OP_HUNT: begin
                    if (sync_hit) begin
                        r_win_high  <= r_sum[16:1];
                        r_win_low   <= {1'b0, r_sum[16:2]};
                        r_short_sum <= '0;
                        r_long_sum  <= '0;
                        r_cycle_sum <= '0;
                        r_phase     <= 4'd1;
                    end else if (short_ok) begin
                        r_short_sum <= short_nx;
                        r_cycle_sum <= cyc_nx;
                        r_phase     <= r_phase + 4'd1;
                    end else if (long_ok) begin
                        r_long_sum  <= long_nx;
                        r_cycle_sum <= cyc_nx;
                        r_phase     <= r_phase + 4'd1;
                    end else if (r_phase != PHASE_HUNT) begin
                        r_phase     <= PHASE_HUNT;
                        r_short_sum <= '0;
                        r_long_sum  <= '0;
                        r_cycle_sum <= '0;
                    end
                end
                OP_CAL: begin
                    r_thr      <= thr_nx;
                    r_avg      <= avg_nx;
                    r_run_len  <= '0;
                    r_run_high <= '0;
                    r_back     <= 1'b0;
                end
                OP_D2: begin
                    if (len_fits) begin
                        r_run_len  <= r_len[16:0];
                        r_run_high <= r_nh;
                        r_back     <= 1'b1;
                    end else if (!back_go) begin
                        r_run_high <= r_nh;
                    end
                end
                OP_D3: begin
                    if (!r_term && dev_small) begin
                        r_run_len  <= '0;
                        r_run_high <= '0;
                        r_back     <= 1'b0;
                    end
                end
                OP_TERM: begin
                    r_phase     <= PHASE_HUNT;
                    r_short_sum <= '0;
                    r_long_sum  <= '0;
                    r_cycle_sum <= '0;
                end
                OP_LOOP: begin
                    if (loop_go) begin
                        r_run_high <= (r_run_high > r_avg) ? (r_run_high - r_avg) : 16'd0;
                    end
                end
                OP_FIN2: begin
                    if (fin_small) begin
                        r_run_len  <= '0;
                        r_run_high <= '0;
                        r_back     <= 1'b0;
                    end else if (r_len < avg_s) begin
                        r_run_len  <= (r_dev > 19'sd65536) ? 17'h10000 : neg_dev[16:0];
                        r_run_high <= '0;
                    end else begin
                        r_run_len  <= (r_dev > 19'sd65535) ? 17'h0FFFF : r_dev[16:0];
                        r_run_high <= (r_dev > 19'sd65535) ? 16'hFFFF : r_dev[15:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_status.decoding   = (r_phase == PHASE_DECODE);
        o_status.full       = full;
        o_status.cnt_zero   = (r_cnt == 4'd0);
        o_status.hunt_cal   = !sync_hit && (short_ok || long_ok) && (r_phase == PHASE_LAST);
        o_status.hunt_again = !sync_hit && !short_ok && !long_ok && (r_phase != PHASE_HUNT);
        o_status.len_fits   = len_fits;
        o_status.term       = r_term;
        o_status.dev_small  = dev_small;
        o_status.again      = r_again;
        o_status.loop_go    = loop_go;
        o_status.drain_done = (r_rd == r_cnt);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== src/pulse_width_bit_decoder.sv =====
// ----------------------------------------------------------------------------
// Pulse width bit decoder
// Each input word is one captured pulse pair (high and low ticks). The block
// hunts for a sync pair and an eight-pair training pattern, reports the
// calibrated bit cycle and high threshold, then decodes bit symbols.
// Input and output are valid/ready channels; configuration is a write port
// of five 16-bit registers. The user must see that they are written only
// while the block is idle; the block itself leaves this unchecked. One word
// is processed at a time. A hunt step runs the hunt state, plus calibration
// when it completes. A decode pass runs steps D1 and D2 and stops when the
// pair fits in the current bit; else step D3 settles a bit at once or
// enters the run loop, which emits run symbols, then steps FIN and FIN2.
// Reprocessing repeats passes, up to eight results per word. Results leave
// the result buffer via the output register as it frees up, the last
// flagged by last. A word causing no result returns to idle after the
// hunt or decode pass. A stalled receiver holds the drain; the next word
// is accepted once the final result sits in the output register.
// Synchronous reset restores register defaults and returns to the sync hunt.
// ----------------------------------------------------------------------------
module pulse_width_bit_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pwbd_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pwbd_pkg::t_out_word o_out_word
);
    import pwbd_pkg::*;

    t_cmd    cmd;
    t_status status;

    pwbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pwbd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_word     (i_in_word),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_word    (o_out_word)
    );

endmodule
